### hw/rtl/fbfla_pkg.sv
`default_nettype none

package fbfla_pkg;

  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned SIZE_W   = 16;
  localparam int unsigned OFFSET_W = 24;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_W    = 16;

  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX  = 2'd2;

  localparam logic ACTION_ALLOC = 1'b0;
  localparam logic ACTION_FREE  = 1'b1;

  localparam logic REG_BLOCK_COUNT = 1'b0;
  localparam logic REG_BLOCK_SIZE  = 1'b1;

  localparam logic [INDEX_W-1:0]  COUNT_SAT        = 8'hff;
  localparam logic [SIZE_W-1:0]   BLOCK_SIZE_RESET = 16'd8;
  localparam logic [INDEX_W-1:0]  BLOCK_COUNT_RESET = 8'd255;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  granted_index;
    logic [OFFSET_W-1:0] byte_offset;
    logic [INDEX_W-1:0]  free_count;
  } result_t;

endpackage

`default_nettype wire

### hw/rtl/fbfla_ram.sv
`default_nettype none

module fbfla_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 255
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### hw/rtl/fixed_block_free_list_allocator_unit.sv
// Fixed-size block free-list allocator.
// Request channel: in_valid / in_stall with action (0 allocate, 1 free) and
// target_index. Result channel: out_valid / out_stall with status,
// granted_index, byte_offset and free_count, exactly one result per item.
// A result shows right after its accepting edge unless out_stall parks it
// in the skid register. Throughput is one item per cycle while in_stall is
// low; the head's link is prefetched from the link RAM (registered read) or
// forwarded from the last free, so back-to-back requests never wait.
// A two-entry output (result register plus skid register) keeps the input
// open while one result waits; in_stall rises only when both are full.
// Configuration: cfg_write with cfg_index (0 block_count, 1 block_size) and
// cfg_data, only while idle. Writing block_count (capped at MAX_BLOCKS)
// rebuilds the free list at once: link i = i+1, head 0, count = blocks.
// Reset (rst, synchronous) does the same with 255 blocks of 8 bytes; per-entry
// valid bits stand in for the link reset, so no clearing pass is needed.
`default_nettype none

module fixed_block_free_list_allocator_unit #(
  parameter int unsigned MAX_BLOCKS = 255
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        action,
  input  wire logic [7:0]  target_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [7:0]       granted_index,
  output logic [23:0]      byte_offset,
  output logic [7:0]       free_count,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int unsigned AW = $clog2(MAX_BLOCKS);
  localparam int unsigned VD = 2 ** AW;
  localparam logic [fbfla_pkg::INDEX_W-1:0] MAX_IDX = fbfla_pkg::INDEX_W'(MAX_BLOCKS);

  logic [fbfla_pkg::INDEX_W-1:0] block_count;
  logic [fbfla_pkg::SIZE_W-1:0]  block_size;
  logic [fbfla_pkg::INDEX_W-1:0] head;
  logic [fbfla_pkg::INDEX_W-1:0] head_next;
  logic [fbfla_pkg::INDEX_W-1:0] free_blocks;
  logic [fbfla_pkg::INDEX_W-1:0] free_blocks_next;
  logic [VD-1:0]                 link_valid;
  logic                          fwd_valid;
  logic [fbfla_pkg::INDEX_W-1:0] fwd_value;
  logic                          rd_valid;
  logic [fbfla_pkg::INDEX_W-1:0] rd_idx;
  logic [fbfla_pkg::INDEX_W-1:0] ram_q;
  logic [fbfla_pkg::INDEX_W-1:0] head_link;
  logic [fbfla_pkg::INDEX_W-1:0] count_wr;

  logic accept;
  logic rebuild;
  logic alloc_ok;
  logic free_ok;

  fbfla_pkg::result_t res_new;
  fbfla_pkg::result_t res_out;
  fbfla_pkg::result_t res_skid;
  logic               skid_valid;
  logic [fbfla_pkg::INDEX_W-1:0] granted;

  assign accept  = in_valid && !in_stall;
  assign rebuild = cfg_write && (cfg_index == fbfla_pkg::REG_BLOCK_COUNT);
  assign count_wr = (cfg_data[7:0] > MAX_IDX) ? MAX_IDX : cfg_data[7:0];

  // link of the current head: forwarded, stored, or the reset pattern
  assign head_link = fwd_valid ? fwd_value
                   : (rd_valid ? ram_q : rd_idx + 8'd1);

  assign alloc_ok = accept && (action == fbfla_pkg::ACTION_ALLOC)
                 && (head != block_count) && (head < MAX_IDX);
  assign free_ok  = accept && (action == fbfla_pkg::ACTION_FREE)
                 && (target_index < block_count) && (target_index < MAX_IDX);

  always_comb begin
    head_next        = head;
    free_blocks_next = free_blocks;
    granted          = '0;
    if (free_ok) begin
      head_next = target_index;
      granted   = target_index;
      if (free_blocks != fbfla_pkg::COUNT_SAT) begin
        free_blocks_next = free_blocks + 8'd1;
      end
    end else if (alloc_ok) begin
      head_next = head_link;
      granted   = head;
      if (free_blocks != '0) begin
        free_blocks_next = free_blocks - 8'd1;
      end
    end
    if (rebuild) begin
      head_next = '0;
    end
  end

  always_comb begin
    res_new.granted_index = granted;
    res_new.byte_offset   = fbfla_pkg::OFFSET_W'(granted) * fbfla_pkg::OFFSET_W'(block_size);
    res_new.free_count    = free_blocks_next;
    if (action == fbfla_pkg::ACTION_ALLOC) begin
      res_new.status = alloc_ok ? fbfla_pkg::STATUS_OK : fbfla_pkg::STATUS_EMPTY;
    end else begin
      res_new.status = free_ok ? fbfla_pkg::STATUS_OK : fbfla_pkg::STATUS_BAD_INDEX;
    end
  end

  fbfla_ram #(
    .WIDTH (fbfla_pkg::INDEX_W),
    .DEPTH (MAX_BLOCKS)
  ) u_links (
    .clk     (clk),
    .wr_en   (free_ok),
    .wr_addr (target_index[AW-1:0]),
    .wr_data (head),
    .rd_addr (head_next[AW-1:0]),
    .rd_data (ram_q)
  );

  always_ff @(posedge clk) begin
    rd_idx   <= head_next;
    rd_valid <= link_valid[head_next[AW-1:0]];
    if (rst) begin
      block_count <= (fbfla_pkg::BLOCK_COUNT_RESET > MAX_IDX) ? MAX_IDX
                   : fbfla_pkg::BLOCK_COUNT_RESET;
      block_size  <= fbfla_pkg::BLOCK_SIZE_RESET;
      head        <= '0;
      free_blocks <= (fbfla_pkg::BLOCK_COUNT_RESET > MAX_IDX) ? MAX_IDX
                   : fbfla_pkg::BLOCK_COUNT_RESET;
      link_valid  <= '0;
      fwd_valid   <= 1'b1;
      fwd_value   <= 8'd1;
    end else if (rebuild) begin
      block_count <= count_wr;
      head        <= '0;
      free_blocks <= count_wr;
      link_valid  <= '0;
      fwd_valid   <= 1'b1;
      fwd_value   <= 8'd1;
    end else begin
      if (cfg_write && (cfg_index == fbfla_pkg::REG_BLOCK_SIZE)) begin
        block_size <= cfg_data;
      end
      head        <= head_next;
      free_blocks <= free_blocks_next;
      if (free_ok) begin
        link_valid[target_index[AW-1:0]] <= 1'b1;
        fwd_valid <= 1'b1;
        fwd_value <= head;
      end else if (alloc_ok) begin
        fwd_valid <= 1'b0;
      end
    end
  end

  // result register with skid stage behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_stall) begin
      if (accept) begin
        res_skid   <= res_new;
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      res_out    <= res_skid;
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else if (accept) begin
      res_out   <= res_new;
      out_valid <= 1'b1;
    end else begin
      out_valid <= 1'b0;
    end
  end

  assign in_stall      = skid_valid;
  assign status        = res_out.status;
  assign granted_index = res_out.granted_index;
  assign byte_offset   = res_out.byte_offset;
  assign free_count    = res_out.free_count;

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("skid holds an item while the result register is empty");

  a_free_sets_head: assert property (@(posedge clk) disable iff (rst)
    free_ok && !cfg_write |=> head == $past(target_index))
    else $error("freed block did not become the head");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != fbfla_pkg::STATUS_OK) |->
      (granted_index == '0) && (byte_offset == '0))
    else $error("failed request reports a nonzero block");
`endif

endmodule

`default_nettype wire

### test/fixed_block_free_list_allocator_unit_tb.sv
`timescale 1ns / 100ps

module fixed_block_free_list_allocator_unit_tb;

  localparam int unsigned CYCLE_LIMIT = 600000;

  class free_list_tracker;
    logic [7:0]  links [0:254];
    logic [7:0]  head;
    logic [7:0]  free_ct;
    logic [7:0]  blocks;
    logic [15:0] bsize;
    fbfla_pkg::result_t pending_results[$];
    int          errors;

    function new();
      blocks = fbfla_pkg::BLOCK_COUNT_RESET;
      bsize = fbfla_pkg::BLOCK_SIZE_RESET;
      errors = 0;
      rebuild();
    endfunction

    function void rebuild();
      for (int i = 0; i < 255; i++) links[i] = 8'(i + 1);
      head = 8'd0;
      free_ct = blocks;
    endfunction

    function void write_reg(logic idx, logic [15:0] data);
      if (idx == fbfla_pkg::REG_BLOCK_COUNT) begin
        blocks = data[7:0];
        rebuild();
      end else begin
        bsize = data;
      end
    endfunction

    // works out the result of one accepted request and queues it
    function fbfla_pkg::result_t note_request(logic act, logic [7:0] idx);
      fbfla_pkg::result_t r;
      r = '0;
      if (act == fbfla_pkg::ACTION_ALLOC) begin
        if (head == blocks || head == 8'hff) begin
          r.status = fbfla_pkg::STATUS_EMPTY;
        end else begin
          r.granted_index = head;
          head = links[head];
          if (free_ct != 8'd0) free_ct--;
        end
      end else begin
        if (idx >= blocks || idx == 8'hff) begin
          r.status = fbfla_pkg::STATUS_BAD_INDEX;
        end else begin
          links[idx] = head;
          head = idx;
          r.granted_index = idx;
          if (free_ct != fbfla_pkg::COUNT_SAT) free_ct++;
        end
      end
      r.byte_offset = 24'(r.granted_index) * 24'(bsize);
      r.free_count = free_ct;
      pending_results.push_back(r);
      return r;
    endfunction

    function void check_result(fbfla_pkg::result_t got);
      fbfla_pkg::result_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d granted_index %0d", got.status,
               got.granted_index);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.granted_index !== want.granted_index) begin
        $error("granted_index: expected %0d, actual %0d", want.granted_index,
               got.granted_index);
        errors++;
      end
      if (got.byte_offset !== want.byte_offset) begin
        $error("byte_offset: expected %0d, actual %0d", want.byte_offset, got.byte_offset);
        errors++;
      end
      if (got.free_count !== want.free_count) begin
        $error("free_count: expected %0d, actual %0d", want.free_count, got.free_count);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        action = fbfla_pkg::ACTION_ALLOC;
  logic [7:0]  target_index = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [7:0]  granted_index;
  logic [23:0] byte_offset;
  logic [7:0]  free_count;
  logic        cfg_write = 1'b0;
  logic        cfg_index = fbfla_pkg::REG_BLOCK_COUNT;
  logic [15:0] cfg_data = 16'd0;

  free_list_tracker sb = new();
  logic [7:0] held[$];
  int         idle_pct = 0;
  bit         tail = 1'b0;
  int unsigned cycles = 0;

  fixed_block_free_list_allocator_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .target_index (target_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .granted_index(granted_index),
    .byte_offset  (byte_offset),
    .free_count   (free_count),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("fixed_block_free_list_allocator_unit: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result({status, granted_index, byte_offset, free_count});
    end
  end

  // receiver stalls in random bursts
  initial begin
    forever begin
      @(posedge clk);
      if (!tail && !rst && $urandom_range(0, 399) < idle_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send(input logic act, input logic [7:0] idx);
    fbfla_pkg::result_t r;
    in_valid <= 1'b1;
    action <= act;
    target_index <= idx;
    do @(posedge clk); while (in_stall);
    r = sb.note_request(act, idx);
    if (act == fbfla_pkg::ACTION_ALLOC && r.status == fbfla_pkg::STATUS_OK) begin
      held.push_back(r.granted_index);
    end
    if (!tail && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    if (idx == fbfla_pkg::REG_BLOCK_COUNT) held.delete();
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(input int n, input int palloc);
    int j;
    logic [7:0] idx;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 80) begin
        // well-formed: free a block we hold, or allocate
        if (held.size() > 0 && ($urandom_range(0, 99) >= palloc || sb.free_ct == 8'd0)) begin
          j = $urandom_range(0, held.size() - 1);
          idx = held[j];
          held.delete(j);
          send(fbfla_pkg::ACTION_FREE, idx);
        end else begin
          send(fbfla_pkg::ACTION_ALLOC, 8'($urandom));
        end
      end else if ($urandom_range(0, 1) == 0) begin
        // stray free: double free or out of range
        send(fbfla_pkg::ACTION_FREE, 8'($urandom_range(0, 255)));
      end else begin
        send(fbfla_pkg::ACTION_ALLOC, 8'($urandom));
      end
    end
  endtask

  task automatic run_phase(input logic [7:0] count, input logic [15:0] size, input int n,
                           input int palloc);
    wait_idle();
    write_reg(fbfla_pkg::REG_BLOCK_COUNT, {8'($urandom), count});
    write_reg(fbfla_pkg::REG_BLOCK_SIZE, size);
    case ($urandom_range(0, 2))
      0: idle_pct = 0;
      1: idle_pct = 10;
      default: idle_pct = 35;
    endcase
    run_random(n, palloc);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    idle_pct = 25;

    // reset state: 255 blocks of 8 bytes
    send(fbfla_pkg::ACTION_ALLOC, 8'hff);
    send(fbfla_pkg::ACTION_ALLOC, 8'h00);
    send(fbfla_pkg::ACTION_FREE, 8'd0);
    send(fbfla_pkg::ACTION_FREE, 8'hff);
    send(fbfla_pkg::ACTION_FREE, 8'd254);
    send(fbfla_pkg::ACTION_FREE, 8'd254);

    // three blocks, widest size: run dry, bad index, double free
    wait_idle();
    write_reg(fbfla_pkg::REG_BLOCK_COUNT, 16'hab03);
    write_reg(fbfla_pkg::REG_BLOCK_SIZE, 16'hffff);
    send(fbfla_pkg::ACTION_ALLOC, 8'd0);
    send(fbfla_pkg::ACTION_ALLOC, 8'd0);
    send(fbfla_pkg::ACTION_ALLOC, 8'd0);
    send(fbfla_pkg::ACTION_ALLOC, 8'd0);
    send(fbfla_pkg::ACTION_FREE, 8'd2);
    send(fbfla_pkg::ACTION_FREE, 8'd3);
    send(fbfla_pkg::ACTION_FREE, 8'd2);
    send(fbfla_pkg::ACTION_ALLOC, 8'd0);
    send(fbfla_pkg::ACTION_ALLOC, 8'd0);

    // zero blocks: everything fails
    wait_idle();
    write_reg(fbfla_pkg::REG_BLOCK_COUNT, 16'hff00);
    send(fbfla_pkg::ACTION_ALLOC, 8'd0);
    send(fbfla_pkg::ACTION_FREE, 8'd0);

    // one block, zero size: double free then count stuck at zero
    wait_idle();
    write_reg(fbfla_pkg::REG_BLOCK_COUNT, 16'h0001);
    write_reg(fbfla_pkg::REG_BLOCK_SIZE, 16'h0000);
    send(fbfla_pkg::ACTION_ALLOC, 8'd0);
    send(fbfla_pkg::ACTION_FREE, 8'd0);
    send(fbfla_pkg::ACTION_FREE, 8'd0);
    send(fbfla_pkg::ACTION_ALLOC, 8'd0);
    send(fbfla_pkg::ACTION_ALLOC, 8'd0);
    send(fbfla_pkg::ACTION_ALLOC, 8'd0);

    run_phase(8'd255, 16'($urandom_range(1, 65535)), 300, 75);
    run_phase(8'd1, 16'd1, 120, 50);
    run_phase(8'd2, 16'hffff, 150, 50);
    run_phase(8'($urandom_range(3, 16)), 16'($urandom), 300, 60);
    run_phase(8'd0, 16'd5, 40, 50);
    run_phase(8'($urandom_range(17, 254)), 16'($urandom), 350, 70);
    run_phase(8'd255, 16'd0, 300, 85);
    run_phase(8'($urandom_range(1, 8)), 16'hffff, 200, 50);
    // no idling on either side for the last stretch
    tail = 1'b1;
    run_random(200, 50);

    wait_idle();
    repeat (5) @(posedge clk);
    if (sb.errors == 0) begin
      $display("fixed_block_free_list_allocator_unit: match");
    end else begin
      $display("fixed_block_free_list_allocator_unit: mismatch");
    end
    $finish;
  end

endmodule

### fixed_block_free_list_allocator_unit.f
hw/rtl/fbfla_pkg.sv
hw/rtl/fbfla_ram.sv
hw/rtl/fixed_block_free_list_allocator_unit.sv
test/fixed_block_free_list_allocator_unit_tb.sv
